### rtl/core/fene_pkg.sv
// ============================================================================
// fene_pkg: shared types and constants
// Register indexes, reset values and fixed widths for the FENE bond block.
// ============================================================================
package fene_pkg;

    localparam int LIMB_W = 32;   // partial product limb width
    localparam int MANT_W = 64;   // log2 mantissa width
    localparam int RES_W  = 48;   // result width, Q24.24

    // ln 2 in Q0.64
    localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;

    // register reset values
    localparam logic [31:0] SPRING_RST = 32'd1966080;
    localparam logic [31:0] MAXEXT_RST = 32'd25165824;
    localparam logic [31:0] CUTOFF_RST = 32'd23488102;

    // saturated magnitudes
    localparam logic [RES_W-1:0] ENERGY_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] FORCE_MIN  = {1'b1, {(RES_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CFG_SPRING = 2'd0,
        CFG_MAXEXT = 2'd1,
        CFG_CUTOFF = 2'd2
    } cfg_idx_t;

endpackage

### rtl/core/fene_bond_energy_force.sv
// ============================================================================
// fene_bond_energy_force: FENE bond energy and force, fixed point
// One pair distance in, one energy/force result out, fully pipelined.
// ============================================================================
// Usage:
//   s_ channel: one beat carries a pair distance r (unsigned, DIST_FRAC_BITS
//   fraction bits). m_ channel: one beat carries energy U and force F
//   (signed Q24.24, saturated) and the bad-setup flag in tuser.
//   cfg_wr_*: write k, r0 and r0in while no beat is in flight.
//   Throughput: one beat per cycle unless the pipeline is frozen (see
//   Stall). Every stage is a register; the quotient row (one cell per
//   quotient bit) and the two log2 rows (one cell per fraction bit) set
//   the depth.
//   Reset: clears all valid bits and loads the reset register values.
//   Stall: the output register holds a result until taken; the pipeline
//   keeps moving (and s_tready stays high) as long as its last stage is
//   empty, and freezes as a whole only when a finished result is queued
//   behind a held output beat.
// ============================================================================
module fene_bond_energy_force
    import fene_pkg::*;
#(
    parameter int DIST_FRAC_BITS = 24,
    parameter int LOG_STAGES     = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream: [31:0] distance
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // result stream: [47:0] bond_energy, [95:48] bond_force
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,
    // result flags: [0] bad_setup
    output logic [0:0]  m_tuser,
    // register writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data
);
    // force: shift of k*d*r0^2/num down to Q24.24; quotient bits kept
    localparam int SHF  = DIST_FRAC_BITS - 8;
    localparam int QW   = SHF + 47;
    localparam int CW   = (128 - QW > 64) ? 128 - QW : 64;
    // energy: shift of k*r0^2*Lnat down to Q24.24
    localparam int RW   = LOG_STAGES + 6;
    localparam int SHE  = 2 * DIST_FRAC_BITS + LOG_STAGES - 7;
    localparam int EPW  = 96 + RW;
    // pipeline positions of the two results, and the common last stage
    localparam int FO   = 6 + QW;
    localparam int EO   = 15 + 2 * LOG_STAGES;
    localparam int LAST = (FO > EO) ? FO : EO;
    localparam int FDL  = LAST - FO;
    localparam int EDL  = LAST - EO;

    // ------------------------------------------------------------------
    // registers and derived constants
    // ------------------------------------------------------------------
    logic [31:0] k_reg, r0_reg, rin_reg;
    logic [63:0] r0sq_reg;
    logic        bad_reg;
    logic [95:0] kr0sq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg   <= SPRING_RST;
            r0_reg  <= MAXEXT_RST;
            rin_reg <= CUTOFF_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SPRING: k_reg   <= cfg_wr_data;
                CFG_MAXEXT: r0_reg  <= cfg_wr_data;
                CFG_CUTOFF: rin_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // these are derived from the registers through their own registers, well before first use
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_reg <= 1'b0;
        end else begin
            bad_reg <= (r0_reg == '0) || (rin_reg >= r0_reg);
        end
    end

    always_ff @(posedge aclk) begin
        r0sq_reg <= 64'(r0_reg) * 64'(r0_reg);
    end

    fene_mul #(.AW(32), .BW(64)) u_mul_kr (
        .clk (aclk),
        .en  (1'b1),
        .a   (k_reg),
        .b   (r0sq_reg),
        .p   (kr0sq)
    );

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    logic [LAST:0] v_reg;
    logic          out_free;
    logic          adv;

    assign out_free = !m_tvalid || m_tready;
    assign adv      = out_free || !v_reg[LAST];
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[LAST-1:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // front: clamp, squares, denominator
    // ------------------------------------------------------------------
    logic [31:0] r_reg, d_reg;
    logic [63:0] dsq_reg, kd_reg, num_reg, num_d_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg     <= s_tdata;
            d_reg     <= (r_reg < rin_reg) ? r_reg : rin_reg;
            dsq_reg   <= 64'(d_reg) * 64'(d_reg);
            kd_reg    <= 64'(k_reg) * 64'(d_reg);
            num_reg   <= r0sq_reg - dsq_reg;
            num_d_reg <= num_reg;
        end
    end

    // ------------------------------------------------------------------
    // force: k*d*r0^2 / num through a row of quotient cells
    // ------------------------------------------------------------------
    logic [127:0]  t4;
    logic [CW-1:0] rem0;
    logic [63:0]   rem_c [QW+1];
    logic [QW-1:0] dq_c  [QW+1];
    logic [63:0]   num_c [QW+1];
    logic          sat_c [QW+1];
    logic [63:0]   rem_reg, numq_reg;
    logic [QW-1:0] dq_reg;
    logic          fsat_reg;
    logic [RES_W-1:0] fres_reg, f_end;

    fene_mul #(.AW(64), .BW(64)) u_mul_t4 (
        .clk (aclk),
        .en  (adv),
        .a   (kd_reg),
        .b   (r0sq_reg),
        .p   (t4)
    );

    // high part at or above num means the quotient overflows the range
    assign rem0 = CW'(t4[127:QW]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            fsat_reg <= rem0 >= CW'(num_d_reg);
            rem_reg  <= rem0[63:0];
            dq_reg   <= t4[QW-1:0];
            numq_reg <= num_d_reg;
        end
    end

    assign rem_c[0] = rem_reg;
    assign dq_c[0]  = dq_reg;
    assign num_c[0] = numq_reg;
    assign sat_c[0] = fsat_reg;

    for (genvar i = 0; i < QW; i++) begin : g_div
        fene_div_cell #(.QW(QW)) u_cell (
            .clk     (aclk),
            .en      (adv),
            .rem_in  (rem_c[i]),
            .dq_in   (dq_c[i]),
            .num_in  (num_c[i]),
            .sat_in  (sat_c[i]),
            .rem_out (rem_c[i+1]),
            .dq_out  (dq_c[i+1]),
            .num_out (num_c[i+1]),
            .sat_out (sat_c[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fres_reg <= sat_c[QW] ? FORCE_MIN : ('0 - {1'b0, dq_c[QW][QW-1:SHF]});
        end
    end

    // ------------------------------------------------------------------
    // energy: log2(r0^2) - log2(num), times ln 2, times k*r0^2
    // ------------------------------------------------------------------
    logic [RW-1:0]    la, lb, l2_reg;
    logic [RW+63:0]   lnp;
    logic [EPW-1:0]   t5;
    logic             esat;
    logic [RES_W-1:0] eres_reg, e_end;

    fene_log2 #(.LOG_STAGES(LOG_STAGES)) u_log_r0 (
        .clk (aclk),
        .en  (adv),
        .x   (r0sq_reg),
        .l   (la)
    );

    fene_log2 #(.LOG_STAGES(LOG_STAGES)) u_log_num (
        .clk (aclk),
        .en  (adv),
        .x   (num_reg),
        .l   (lb)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            l2_reg <= (la > lb) ? la - lb : '0;
        end
    end

    fene_mul #(.AW(RW), .BW(64)) u_mul_ln (
        .clk (aclk),
        .en  (adv),
        .a   (l2_reg),
        .b   (LN2_Q64),
        .p   (lnp)
    );

    fene_mul #(.AW(96), .BW(RW)) u_mul_e (
        .clk (aclk),
        .en  (adv),
        .a   (kr0sq),
        .b   (lnp[RW+63:64]),
        .p   (t5)
    );

    assign esat = |t5[EPW-1:SHE+47];

    always_ff @(posedge aclk) begin
        if (adv) begin
            eres_reg <= esat ? ENERGY_MAX : {1'b0, t5[SHE+46:SHE]};
        end
    end

    // ------------------------------------------------------------------
    // align the shorter path to the last stage
    // ------------------------------------------------------------------
    if (FDL > 0) begin : g_fdly
        logic [RES_W-1:0] fd_reg [FDL];
        always_ff @(posedge aclk) begin
            if (adv) begin
                fd_reg[0] <= fres_reg;
                for (int i = 1; i < FDL; i++) begin
                    fd_reg[i] <= fd_reg[i-1];
                end
            end
        end
        assign f_end = fd_reg[FDL-1];
    end else begin : g_fnodly
        assign f_end = fres_reg;
    end

    if (EDL > 0) begin : g_edly
        logic [RES_W-1:0] ed_reg [EDL];
        always_ff @(posedge aclk) begin
            if (adv) begin
                ed_reg[0] <= eres_reg;
                for (int i = 1; i < EDL; i++) begin
                    ed_reg[i] <= ed_reg[i-1];
                end
            end
        end
        assign e_end = ed_reg[EDL-1];
    end else begin : g_enodly
        assign e_end = eres_reg;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= v_reg[LAST];
        end
    end

    // bad setup forces zero data
    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_tdata_reg <= bad_reg ? '0 : {f_end, e_end};
            m_tuser_reg <= bad_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

### rtl/core/fene_mul.sv
// ============================================================================
// fene_mul: pipelined wide multiplier
// 32x32 partial products registered, then summed into a registered product.
// ============================================================================
module fene_mul
    import fene_pkg::*;
#(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  logic              clk,
    input  logic              en,
    input  logic [AW-1:0]     a,
    input  logic [BW-1:0]     b,
    output logic [AW+BW-1:0]  p
);
    localparam int NA  = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB  = (BW + LIMB_W - 1) / LIMB_W;
    localparam int AXW = NA * LIMB_W;
    localparam int BXW = NB * LIMB_W;
    localparam int PXW = AXW + BXW;

    logic [AXW-1:0]          a_ext;
    logic [BXW-1:0]          b_ext;
    logic [2*LIMB_W-1:0]     pp_reg [NA][NB];
    logic [PXW-1:0]          acc;
    logic [AW+BW-1:0]        p_reg;

    assign a_ext = AXW'(a);
    assign b_ext = BXW'(b);

    always_ff @(posedge clk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= (2*LIMB_W)'(a_ext[LIMB_W*i +: LIMB_W])
                                  * (2*LIMB_W)'(b_ext[LIMB_W*j +: LIMB_W]);
                end
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (PXW'(pp_reg[i][j]) << (LIMB_W * (i + j)));
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            p_reg <= acc[AW+BW-1:0];
        end
    end

    assign p = p_reg;

endmodule

### rtl/core/fene_log_cell.sv
// ============================================================================
// fene_log_cell: one fraction bit of log2
// Squares the mantissa (partial products, then sum) and emits one bit.
// ============================================================================
module fene_log_cell
    import fene_pkg::*;
#(
    parameter int RW = 30
) (
    input  logic              clk,
    input  logic              en,
    input  logic [MANT_W-1:0] m_in,
    input  logic [RW-1:0]     r_in,
    output logic [MANT_W-1:0] m_out,
    output logic [RW-1:0]     r_out
);
    logic [63:0]        hh_reg, hl_reg, ll_reg;
    logic [RW-1:0]      rs_reg;
    logic [127:0]       sq;
    logic [63:0]        m2;
    logic [MANT_W-1:0]  m_reg;
    logic [RW-1:0]      r_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            hh_reg <= 64'(m_in[63:32]) * 64'(m_in[63:32]);
            hl_reg <= 64'(m_in[63:32]) * 64'(m_in[31:0]);
            ll_reg <= 64'(m_in[31:0])  * 64'(m_in[31:0]);
            rs_reg <= r_in;
        end
    end

    // m^2 >> 62; mantissa sits in [2^62, 2^63)
    assign sq = {hh_reg, 64'b0} + (128'(hl_reg) << 33) + 128'(ll_reg);
    assign m2 = sq[125:62];

    always_ff @(posedge clk) begin
        if (en) begin
            m_reg <= m2[63] ? {1'b0, m2[63:1]} : m2;
            r_reg <= {rs_reg[RW-2:0], m2[63]};
        end
    end

    assign m_out = m_reg;
    assign r_out = r_reg;

endmodule

### rtl/core/fene_log2.sv
// ============================================================================
// fene_log2: pipelined fixed-point log2
// Six normalize steps, then a row of log cells, one fraction bit each.
// ============================================================================
module fene_log2
    import fene_pkg::*;
#(
    parameter int LOG_STAGES = 24
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [MANT_W-1:0]       x,
    output logic [LOG_STAGES+5:0]   l
);
    localparam int RW = LOG_STAGES + 6;
    localparam int NSTEP = 6;

    logic [MANT_W-1:0] ny_reg [NSTEP];
    logic [5:0]        lz_reg [NSTEP];
    logic [MANT_W-1:0] m_c [LOG_STAGES+1];
    logic [RW-1:0]     r_c [LOG_STAGES+1];

    // leading zero count by binary shift search, each step registered
    for (genvar j = 0; j < NSTEP; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic [MANT_W-1:0] y_in;
        logic [5:0]        z_in;
        if (j == 0) begin : g_first
            assign y_in = x;
            assign z_in = '0;
        end else begin : g_next
            assign y_in = ny_reg[j-1];
            assign z_in = lz_reg[j-1];
        end
        always_ff @(posedge clk) begin
            if (en) begin
                if (y_in[MANT_W-1 -: SH] == '0) begin
                    ny_reg[j] <= y_in << SH;
                    lz_reg[j] <= z_in | 6'(SH);
                end else begin
                    ny_reg[j] <= y_in;
                    lz_reg[j] <= z_in;
                end
            end
        end
    end

    // integer part = 63 - lz; mantissa leading one at bit 62
    assign m_c[0] = {1'b0, ny_reg[NSTEP-1][MANT_W-1:1]};
    assign r_c[0] = RW'(~lz_reg[NSTEP-1]);

    for (genvar i = 0; i < LOG_STAGES; i++) begin : g_cell
        fene_log_cell #(.RW(RW)) u_cell (
            .clk   (clk),
            .en    (en),
            .m_in  (m_c[i]),
            .r_in  (r_c[i]),
            .m_out (m_c[i+1]),
            .r_out (r_c[i+1])
        );
    end

    assign l = r_c[LOG_STAGES];

endmodule

### rtl/core/fene_div_cell.sv
// ============================================================================
// fene_div_cell: one restoring division step
// Shifts in one dividend bit, trial-subtracts the divisor, emits one
// quotient bit.
// ============================================================================
module fene_div_cell #(
    parameter int QW = 63
) (
    input  logic          clk,
    input  logic          en,
    input  logic [63:0]   rem_in,
    input  logic [QW-1:0] dq_in,
    input  logic [63:0]   num_in,
    input  logic          sat_in,
    output logic [63:0]   rem_out,
    output logic [QW-1:0] dq_out,
    output logic [63:0]   num_out,
    output logic          sat_out
);
    logic [64:0]   rem_sh;
    logic [64:0]   diff;
    logic          ge;
    logic [63:0]   rem_reg;
    logic [QW-1:0] dq_reg;
    logic [63:0]   num_reg;
    logic          sat_reg;

    assign rem_sh = {rem_in, dq_in[QW-1]};
    assign ge     = rem_sh >= {1'b0, num_in};
    assign diff   = rem_sh - {1'b0, num_in};

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge clk) begin
        if (en) begin
            rem_reg <= ge ? diff[63:0] : rem_sh[63:0];
            dq_reg  <= {dq_in[QW-2:0], ge};
            num_reg <= num_in;
            sat_reg <= sat_in;
        end
    end

    assign rem_out = rem_reg;
    assign dq_out  = dq_reg;
    assign num_out = num_reg;
    assign sat_out = sat_reg;

endmodule

### rtl/core/fene_checker.sv
// ============================================================================
// fene_checker: port-level checks for the FENE bond block
// Watches the result stream; bound to the top level.
// ============================================================================
module fene_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // held beat keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // bad setup beats carry zero energy and force
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("bad setup beat with nonzero data");

    // energy never negative, force never positive
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[47] && (m_tdata[95] || m_tdata[95:48] == '0))
        else $error("energy or force has the wrong sign");

    // nothing leaves right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind fene_bond_energy_force fene_checker u_fene_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for fene_bond_energy_force
// Streams pair distances through the block under a series of register
// settings, predicts energy, force and the bad-setup flag in wide integer
// math, and compares every result beat against the oldest expectation.
// ============================================================================
module tb_top;
    import fene_pkg::*;

    localparam int          CLK_HALF     = 10;
    localparam int          PIPE_WAIT    = 100;      // longer than the block's latency
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          LONG_HOLD    = 400;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;     // index with no register
    localparam logic [47:0] MAG_LIMIT    = 48'h8000_0000_0000;

    typedef struct packed {
        logic [47:0] energy;
        logic [47:0] force_val;
        logic        bad;
    } bond_res_t;

    typedef struct {
        logic [31:0] k;
        logic [31:0] r0;
        logic [31:0] cut;
        logic [31:0] r_val;
        bit          typed;      // expected value given in the row
        bond_res_t   res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_index = '0;
    logic [31:0] cfg_wr_data = '0;

    // bench copy of the register file
    logic [31:0] k_reg = SPRING_RST;
    logic [31:0] r0_reg = MAXEXT_RST;
    logic [31:0] cut_reg = CUTOFF_RST;

    bond_res_t   pending_res[$];
    int          mismatches = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          cycles = 0;
    int          stall_mode = 0; // 0 always ready, 1 random, 2 pattern
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_cnt = 0;
    bit          cur_typed = 0;
    bond_res_t   cur_expect;

    fene_bond_energy_force dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // log2 with 24 truncated fraction bits, square-and-compare on a Q1.62
    // mantissa
    function automatic logic [63:0] log2_q24(input logic [63:0] x);
        int           msb;
        logic [63:0]  mant;
        logic [63:0]  acc;
        logic [127:0] sq;
        msb = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) msb = i;
        end
        mant = (msb == 63) ? (x >> 1) : (x << (62 - msb));
        acc = 64'(msb);
        for (int i = 0; i < 24; i++) begin
            sq = 128'(mant) * 128'(mant);
            mant = sq[125:62];
            acc = acc << 1;
            if (mant[63]) begin
                acc[0] = 1'b1;
                mant = mant >> 1;
            end
        end
        return acc;
    endfunction

    function automatic bond_res_t fene_predict(input logic [31:0] r);
        bond_res_t    res;
        logic [31:0]  d;
        logic [63:0]  r0sq, num, la, lb, l2, lnat;
        logic [127:0] fquot, lprod;
        logic [191:0] eprod;
        logic [63:0]  fmag, emag;
        res = '0;
        if (r0_reg == 0 || cut_reg >= r0_reg) begin
            res.bad = 1'b1;
            return res;
        end
        d = (r < cut_reg) ? r : cut_reg;
        r0sq = 64'(r0_reg) * 64'(r0_reg);
        num = r0sq - 64'(d) * 64'(d);

        // force: k*d*r0^2/num, Q16.16 * Q8.24 -> drop 16 bits
        fquot = (128'(k_reg) * 128'(d) * 128'(r0sq)) / 128'(num);
        fquot = fquot >> 16;
        fmag = (fquot > 128'(MAG_LIMIT)) ? 64'(MAG_LIMIT) : fquot[63:0];

        // energy: k*r0^2*ln(r0^2/num)/2
        la = log2_q24(r0sq);
        lb = log2_q24(num);
        l2 = (la > lb) ? la - lb : 64'd0;
        lprod = 128'(l2) * 128'(LN2_Q64);
        lnat = lprod[127:64];
        eprod = 192'(k_reg) * 192'(r0sq) * 192'(lnat);
        eprod = eprod >> 65;
        emag = (eprod > 192'(MAG_LIMIT)) ? 64'(MAG_LIMIT) : eprod[63:0];
        if (emag >= 64'(MAG_LIMIT)) emag = 64'(MAG_LIMIT) - 1;

        res.energy = emag[47:0];
        res.force_val = 48'(-fmag);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: expectations are made as the input beat is taken
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            pending_res.push_back(cur_typed ? cur_expect : fene_predict(s_tdata));
            beats_in++;
        end
    end

    always @(posedge aclk) begin
        bond_res_t want;
        bond_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.energy = m_tdata[47:0];
            got.force_val = m_tdata[95:48];
            got.bad = m_tuser[0];
            beats_out++;
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing expected: E=%h F=%h bad=%b",
                             got.energy, got.force_val, got.bad);
            end else begin
                want = pending_res.pop_front();
                if (want.energy !== got.energy || want.force_val !== got.force_val ||
                    want.bad !== got.bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: beat %0d exp E=%h F=%h bad=%b got E=%h F=%h bad=%b",
                                 beats_out, want.energy, want.force_val, want.bad,
                                 got.energy, got.force_val, got.bad);
                end
            end
        end
    end

    // Receiver: always ready, random or pattern stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= LONG_HOLD) hold_done <= 1'b1;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 99) < 60);
                default: m_tready <= ((cycles % 7) < 3) || ((cycles % 23) == 5);
            endcase
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    int burst_left = 0;

    // offer one beat; valid stays high into the next beat unless a gap follows
    task automatic send_dist(input logic [31:0] v, input bit typed, input bond_res_t exp_res);
        cur_typed <= typed;
        cur_expect <= exp_res;
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    // wait until all results are back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        cur_typed <= 0;
        @(posedge aclk);
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (PIPE_WAIT) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SPRING: k_reg = val;
            CFG_MAXEXT: r0_reg = val;
            CFG_CUTOFF: cut_reg = val;
            default: ;   // no register behind this index
        endcase
    endtask

    task automatic set_regs(input logic [31:0] k, input logic [31:0] r0, input logic [31:0] cut);
        drain();
        cfg_write(CFG_SPRING, k);
        cfg_write(CFG_MAXEXT, r0);
        cfg_write(CFG_CUTOFF, cut);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_dist();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 && cut_reg != 0) return $urandom_range(0, cut_reg - 1);
        if (sel < 8) return cut_reg + $urandom_range(0, 8) - 4;
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: extremes, clamp, bad setup, saturation
    // ------------------------------------------------------------------------
    dir_row_t dir_tbl[$];

    task automatic add_row(input logic [31:0] k, input logic [31:0] r0, input logic [31:0] cut,
                           input logic [31:0] r_val, input bit typed,
                           input logic [47:0] e, input logic [47:0] f, input logic bad);
        dir_row_t row;
        row.k = k; row.r0 = r0; row.cut = cut; row.r_val = r_val; row.typed = typed;
        row.res.energy = e; row.res.force_val = f; row.res.bad = bad;
        dir_tbl.push_back(row);
    endtask

    initial begin
        bond_res_t   none;
        logic [31:0] rk, rr0, rcut;
        int          n_items;
        none = '0;

        // reset values: zero distance gives zero energy and force
        add_row(SPRING_RST, MAXEXT_RST, CUTOFF_RST, 32'd0, 1, 48'd0, 48'd0, 1'b0);
        add_row(SPRING_RST, MAXEXT_RST, CUTOFF_RST, 32'd1, 0, 0, 0, 0);
        add_row(SPRING_RST, MAXEXT_RST, CUTOFF_RST, 32'h0100_0000, 0, 0, 0, 0);
        add_row(SPRING_RST, MAXEXT_RST, CUTOFF_RST, CUTOFF_RST - 1, 0, 0, 0, 0);
        add_row(SPRING_RST, MAXEXT_RST, CUTOFF_RST, CUTOFF_RST, 0, 0, 0, 0);    // clamp
        add_row(SPRING_RST, MAXEXT_RST, CUTOFF_RST, 32'hFFFF_FFFF, 0, 0, 0, 0); // clamp
        add_row(SPRING_RST, MAXEXT_RST, CUTOFF_RST, 32'h8000_0000, 0, 0, 0, 0);
        // bad setup: r0 zero, cutoff equal to r0, cutoff above r0
        add_row(SPRING_RST, 32'd0, 32'd0, 32'h0080_0000, 1, 48'd0, 48'd0, 1'b1);
        add_row(SPRING_RST, 32'd0, 32'd5, 32'hFFFF_FFFF, 1, 48'd0, 48'd0, 1'b1);
        add_row(SPRING_RST, MAXEXT_RST, MAXEXT_RST, 32'd1000, 1, 48'd0, 48'd0, 1'b1);
        add_row(SPRING_RST, 32'd100, 32'hFFFF_FFFF, 32'd0, 1, 48'd0, 48'd0, 1'b1);
        // zero stiffness
        add_row(32'd0, MAXEXT_RST, CUTOFF_RST, 32'h0120_0000, 1, 48'd0, 48'd0, 1'b0);
        // widest setting: hard saturation of both outputs, and zero distance
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 0, 0, 0, 0);
        // tiny r0, cutoff just below it
        add_row(32'h0001_0000, 32'd2, 32'd1, 32'd1, 0, 0, 0, 0);
        add_row(32'h0001_0000, 32'd2, 32'd1, 32'd7, 0, 0, 0, 0);
        add_row(32'h0001_0000, 32'd1, 32'd0, 32'd9, 0, 0, 0, 0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stray index must not disturb any register
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
        cfg_write(CFG_UNUSED, 32'h0000_0000);

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].k != k_reg || dir_tbl[i].r0 != r0_reg || dir_tbl[i].cut != cut_reg)
                set_regs(dir_tbl[i].k, dir_tbl[i].r0, dir_tbl[i].cut);
            send_dist(dir_tbl[i].r_val, dir_tbl[i].typed, dir_tbl[i].res);
        end
        cur_typed <= 0;

        // random phases: each gets its own register setting and one of three stall styles
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin rk = SPRING_RST; rr0 = MAXEXT_RST; rcut = CUTOFF_RST; end
                1: begin rk = 32'hFFFF_FFFF; rr0 = 32'hFFFF_FFFF; rcut = 32'hFFFF_FFFE; end
                2: begin rk = 32'd0; rr0 = 32'h0200_0000; rcut = 32'h01FF_0000; end
                3: begin rk = 32'd1; rr0 = 32'd16; rcut = 32'd15; end
                4: begin rk = $urandom; rr0 = $urandom; rcut = $urandom; end  // often bad
                default: begin
                    rk = $urandom;
                    rr0 = $urandom | 32'h1;
                    rcut = $urandom_range(0, rr0 - 1);
                end
            endcase
            set_regs(rk, rr0, rcut);
            stall_mode = ph % 3;
            if (ph == 5) hold_req <= 1'b1;   // long back-pressure, sender keeps going
            n_items = (ph == 3) ? 60 : 200;
            for (int i = 0; i < n_items; i++)
                send_dist(pick_dist(), 0, none);
        end

        drain();
        $display("Covered %0d beats in, %0d results out, %0d register settings,",
                 beats_in, beats_out, 9 + 9);
        $display("including bad setups, clamping, saturation and a %0d-cycle output hold.",
                 LONG_HOLD);
        if (mismatches == 0 && pending_res.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("ERROR: %0d mismatches, %0d results missing",
                     mismatches, pending_res.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### fene_bond_energy_force.f
rtl/core/fene_pkg.sv
rtl/core/fene_mul.sv
rtl/core/fene_log_cell.sv
rtl/core/fene_log2.sv
rtl/core/fene_div_cell.sv
rtl/core/fene_bond_energy_force.sv
rtl/core/fene_checker.sv
sim/tb_top.sv
